@@ rtl/ppt_pkg.sv @@
// Shared types and constants for the projective point transform.
// No dependencies; every other file imports this package.
package ppt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int VEC_W         = 32;
   localparam int Q_W           = VEC_W + 1;
   localparam int LANES         = 3;

   typedef enum logic [1:0] {
      OP_POINT = 2'd0,
      OP_COL   = 2'd1,
      OP_ROW   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_ROW0_LEFT  = 3'd0,
      REG_ROW0_RIGHT = 3'd1,
      REG_ROW1_LEFT  = 3'd2,
      REG_ROW1_RIGHT = 3'd3,
      REG_ROW2_LEFT  = 3'd4,
      REG_ROW2_RIGHT = 3'd5,
      REG_ROW3_LEFT  = 3'd6,
      REG_ROW3_RIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] z_in;
      logic signed [31:0] w_in;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] x_out;
      logic signed [31:0] y_out;
      logic signed [31:0] z_out;
      logic signed [31:0] w_out;
      logic               saturated;
      logic               divide_by_zero;
   } rsp_item_type;

   // results that bypass the divider, carried alongside it
   typedef struct packed {
      op_type           op;
      logic [3:0][31:0] res;
      logic             sat;
      logic             dz;
   } side_type;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

endpackage

@@ rtl/ppt_mac.sv @@
// Multiply and accumulate stages: sixteen products, then four row sums.
// Depends on ppt_pkg.
module ppt_mac import ppt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int ACC_W = 66 - FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  req_item_type           in_item,
   input  logic [15:0][31:0]      matrix,
   output logic                   out_valid,
   output op_type                 out_op,
   output logic [3:0][ACC_W-1:0]  out_acc
);

   localparam int SH_W = 64 - FRAC_BITS;
   localparam logic signed [31:0] ONE_Q = 32'(64'(1) << FRAC_BITS);

   logic signed [31:0]    vec [4];
   logic signed [31:0]    elem [16];
   logic signed [63:0]    full [16];
   logic signed [63:0]    shifted [16];
   logic [SH_W-1:0]       prod_in [16];
   logic [SH_W-1:0]       prod_ff [16];
   logic                  valid1_ff;
   op_type                op1_ff;
   logic [3:0][ACC_W-1:0] acc_in;
   logic [3:0][ACC_W-1:0] acc_ff;
   logic                  valid2_ff;
   op_type                op2_ff;

   always_comb begin
      vec[0] = in_item.x_in;
      vec[1] = in_item.y_in;
      vec[2] = in_item.z_in;
      vec[3] = (in_item.op == OP_POINT) ? ONE_Q : in_item.w_in;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            // row-vector mode walks the matrix transposed
            elem[r*4+c] = (in_item.op == OP_ROW) ? $signed(matrix[c*4+r])
                                                 : $signed(matrix[r*4+c]);
            full[r*4+c]    = elem[r*4+c] * vec[c];
            shifted[r*4+c] = full[r*4+c] >>> FRAC_BITS;
            prod_in[r*4+c] = shifted[r*4+c][SH_W-1:0];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         acc_in[r] = ACC_W'($signed(prod_ff[r*4]))   + ACC_W'($signed(prod_ff[r*4+1]))
                   + ACC_W'($signed(prod_ff[r*4+2])) + ACC_W'($signed(prod_ff[r*4+3]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         op1_ff  <= in_item.op;
         acc_ff  <= acc_in;
         op2_ff  <= op1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_op    = op2_ff;
   assign out_acc   = acc_ff;

endmodule

@@ rtl/ppt_div_step.sv @@
// One restoring division step for the three numerator lanes, registered.
// Depends on ppt_pkg.
module ppt_div_step import ppt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int BIT = 0,
   localparam int DW = 65 - FRAC_BITS,
   localparam int PW = DW + 1,
   localparam int NW = DW + FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic [DW-1:0]             in_d,
   input  logic [LANES-1:0][PW-1:0]  in_p,
   input  logic [LANES-1:0][NW-1:0]  in_n,
   input  logic [LANES-1:0][Q_W-1:0] in_q,
   output logic                      out_valid,
   output logic [DW-1:0]             out_d,
   output logic [LANES-1:0][PW-1:0]  out_p,
   output logic [LANES-1:0][NW-1:0]  out_n,
   output logic [LANES-1:0][Q_W-1:0] out_q
);

   logic [PW-1:0]                trial [LANES];
   logic                         ge [LANES];
   logic [LANES-1:0][PW-1:0]     p_in;
   logic [LANES-1:0][Q_W-1:0]    q_in;
   logic                         valid_ff;
   logic [DW-1:0]                d_ff;
   logic [LANES-1:0][PW-1:0]     p_ff;
   logic [LANES-1:0][NW-1:0]     n_ff;
   logic [LANES-1:0][Q_W-1:0]    q_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         // bring down the next numerator bit
         trial[l] = {in_p[l][PW-2:0], in_n[l][BIT]};
         ge[l]    = trial[l] >= PW'(in_d);
         p_in[l]  = ge[l] ? trial[l] - PW'(in_d) : trial[l];
         q_in[l]      = in_q[l];
         q_in[l][BIT] = ge[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff <= in_d;
         p_ff <= p_in;
         n_ff <= in_n;
         q_ff <= q_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_d     = d_ff;
   assign out_p     = p_ff;
   assign out_n     = n_ff;
   assign out_q     = q_ff;

endmodule

@@ rtl/ppt_divider.sv @@
// Perspective divide: sign/magnitude prep, then one quotient bit per stage.
// Depends on ppt_pkg and ppt_div_step; also clamps the non-divided results.
module ppt_divider import ppt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int ACC_W = 66 - FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  op_type                    in_op,
   input  logic [3:0][ACC_W-1:0]     in_acc,
   output logic                      out_valid,
   output logic [LANES-1:0][Q_W-1:0] out_q,
   output logic [LANES-1:0]          out_neg,
   output side_type                  out_side
);

   localparam int DW = ACC_W - 1;
   localparam int PW = DW + 1;
   localparam int NW = DW + FRAC_BITS;

   function automatic logic [32:0] clamp_q(input logic signed [ACC_W-1:0] a);
      logic [32:0] r;
      if (a > ACC_W'(Q_MAX)) begin
         r = {1'b1, Q_MAX};
      end else if (a < ACC_W'(Q_MIN)) begin
         r = {1'b1, Q_MIN};
      end else begin
         r = {1'b0, a[31:0]};
      end
      return r;
   endfunction

   function automatic logic [DW-1:0] mag(input logic signed [ACC_W-1:0] a);
      logic [ACC_W-1:0] t;
      t = a[ACC_W-1] ? -a : a;
      return t[DW-1:0];
   endfunction

   logic [32:0]                  clamped [4];
   side_type                     side_in;
   logic [LANES-1:0][NW-1:0]     n_in;
   logic [LANES-1:0]             neg_in;

   logic                         valid0_ff;
   logic [DW-1:0]                d0_ff;
   logic [LANES-1:0][NW-1:0]     n0_ff;
   logic [LANES-1:0]             neg0_ff;
   side_type                     side0_ff;

   logic                         valid_s [Q_W+1];
   logic [DW-1:0]                d_s [Q_W+1];
   logic [LANES-1:0][PW-1:0]     p_s [Q_W+1];
   logic [LANES-1:0][NW-1:0]     n_s [Q_W+1];
   logic [LANES-1:0][Q_W-1:0]    q_s [Q_W+1];

   side_type                     side_ff [Q_W];
   logic [LANES-1:0]             neg_ff [Q_W];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         clamped[r] = clamp_q($signed(in_acc[r]));
      end
      for (int l = 0; l < LANES; l++) begin
         n_in[l]   = NW'(mag($signed(in_acc[l]))) << FRAC_BITS;
         neg_in[l] = in_acc[l][ACC_W-1] ^ in_acc[3][ACC_W-1];
      end
      side_in    = '0;
      side_in.op = in_op;
      case (in_op)
         OP_POINT: begin
            if (in_acc[3] == '0) begin
               side_in.dz = 1'b1;
            end else begin
               side_in.res[3] = clamped[3][31:0];
               side_in.sat    = clamped[3][32];
            end
         end
         OP_COL, OP_ROW: begin
            for (int r = 0; r < 4; r++) begin
               side_in.res[r] = clamped[r][31:0];
            end
            side_in.sat = clamped[0][32] | clamped[1][32] | clamped[2][32] | clamped[3][32];
         end
         default: begin
            side_in.op = in_op;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (enable) begin
         valid0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d0_ff    <= mag($signed(in_acc[3]));
         n0_ff    <= n_in;
         neg0_ff  <= neg_in;
         side0_ff <= side_in;
      end
   end

   // the first step sees the top numerator bits; a set top quotient bit means overflow
   always_comb begin
      valid_s[0] = valid0_ff;
      d_s[0]     = d0_ff;
      n_s[0]     = n0_ff;
      q_s[0]     = '0;
      for (int l = 0; l < LANES; l++) begin
         p_s[0][l] = PW'(n0_ff[l][NW-1:Q_W]);
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      ppt_div_step #(
         .FRAC_BITS (FRAC_BITS),
         .BIT       (Q_W - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (valid_s[k]),
         .in_d      (d_s[k]),
         .in_p      (p_s[k]),
         .in_n      (n_s[k]),
         .in_q      (q_s[k]),
         .out_valid (valid_s[k+1]),
         .out_d     (d_s[k+1]),
         .out_p     (p_s[k+1]),
         .out_n     (n_s[k+1]),
         .out_q     (q_s[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side0_ff;
         neg_ff[0]  <= neg0_ff;
         for (int i = 1; i < Q_W; i++) begin
            side_ff[i] <= side_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
         end
      end
   end

   assign out_valid = valid_s[Q_W];
   assign out_q     = q_s[Q_W];
   assign out_neg   = neg_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

@@ rtl/projective_point_transform.sv @@
// Projective 4x4 vertex transform, signed fixed point, fully pipelined.
// An accepted request beat passes through 2 multiply/sum stages, 1 divide prep,
// 33 quotient-bit stages and 1 output stage before its response beat.
// Throughput: one beat per cycle; the whole pipe holds while a response beat is stalled.
// Reset (synchronous) empties the pipe and loads the identity matrix.
module projective_point_transform import ppt_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int ACC_W = 66 - FRAC_BITS;
   localparam logic [63:0] ONE_FIX = 64'(1) << FRAC_BITS;

   logic [7:0][63:0]          csr_ff;
   logic [15:0][31:0]         matrix;
   logic                      enable;
   logic                      mac_valid;
   op_type                    mac_op;
   logic [3:0][ACC_W-1:0]     mac_acc;
   logic                      div_valid;
   logic [LANES-1:0][Q_W-1:0] div_q;
   logic [LANES-1:0]          div_neg;
   side_type                  div_side;
   logic [32:0]               lane [LANES];
   rsp_item_type              rsp_item_in;
   rsp_item_type              rsp_item_ff;
   logic                      rsp_valid_ff;

   // sign and clamp one quotient: {saturated, value}
   function automatic logic [32:0] lane_out(input logic [Q_W-1:0] q, input logic neg);
      logic [31:0] m;
      logic [32:0] r;
      m = q[31:0];
      if (!neg) begin
         r = (q[32] | q[31]) ? {1'b1, Q_MAX} : {1'b0, m};
      end else if (q[32] | (q[31] & (|q[30:0]))) begin
         r = {1'b1, Q_MIN};
      end else begin
         r = {1'b0, -m};
      end
      return r;
   endfunction

   // identity matrix in register form
   function automatic logic [7:0][63:0] csr_reset_value();
      logic [7:0][63:0] v;
      v                 = '0;
      v[REG_ROW0_LEFT]  = ONE_FIX << 32;
      v[REG_ROW1_LEFT]  = ONE_FIX;
      v[REG_ROW2_RIGHT] = ONE_FIX << 32;
      v[REG_ROW3_RIGHT] = ONE_FIX;
      return v;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= csr_reset_value();
      end else if (csr_valid) begin
         csr_ff[csr_index] <= csr_data;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         matrix[r*4]   = csr_ff[2*r][63:32];
         matrix[r*4+1] = csr_ff[2*r][31:0];
         matrix[r*4+2] = csr_ff[2*r+1][63:32];
         matrix[r*4+3] = csr_ff[2*r+1][31:0];
      end
   end

   // advance everything unless a response beat is held
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   ppt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .matrix    (matrix),
      .out_valid (mac_valid),
      .out_op    (mac_op),
      .out_acc   (mac_acc)
   );

   ppt_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (mac_valid),
      .in_op     (mac_op),
      .in_acc    (mac_acc),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_neg   (div_neg),
      .out_side  (div_side)
   );

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane[l] = lane_out(div_q[l], div_neg[l]);
      end
      rsp_item_in = '0;
      if (div_side.op == OP_POINT && !div_side.dz) begin
         rsp_item_in.x_out     = lane[0][31:0];
         rsp_item_in.y_out     = lane[1][31:0];
         rsp_item_in.z_out     = lane[2][31:0];
         rsp_item_in.w_out     = div_side.res[3];
         rsp_item_in.saturated = lane[0][32] | lane[1][32] | lane[2][32] | div_side.sat;
      end else begin
         rsp_item_in.x_out     = div_side.res[0];
         rsp_item_in.y_out     = div_side.res[1];
         rsp_item_in.z_out     = div_side.res[2];
         rsp_item_in.w_out     = div_side.res[3];
         rsp_item_in.saturated = div_side.sat;
      end
      rsp_item_in.divide_by_zero = div_side.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ rtl/ppt_checker.sv @@
// Port-level checks for projective_point_transform, bound to the top level.
// Depends on ppt_pkg.
module ppt_checker import ppt_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("response beat changed while stalled");

   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.divide_by_zero |->
         rsp_item.x_out == 0 && rsp_item.y_out == 0 && rsp_item.z_out == 0 &&
         rsp_item.w_out == 0 && !rsp_item.saturated)
      else $error("zero denominator beat carries data");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind projective_point_transform ppt_checker u_ppt_checker (.*);
